### rtl/pde_pkg.sv
// Shared types and constants for the postfix digit evaluator.
// Used by the front end, back end and top level under rtl; depends on nothing else.
`default_nettype none

package pde_pkg;

   // Character codes the front end recognizes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_OP_FIRST  = 3'd1,
      STATUS_FEW       = 3'd2,
      STATUS_BAD_SYM   = 3'd3,
      STATUS_BAD_DEPTH = 3'd4,
      STATUS_OVERFLOW  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CMD_DIGIT,
      CMD_ADD,
      CMD_SUB,
      CMD_MUL,
      CMD_BAD,
      CMD_FINISH
   } cmd_kind_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       finish;
   } req_type;

   typedef struct packed {
      logic               done_res;
      status_type         status;
      logic signed [7:0]  value;
   } rsp_type;

   // Classified item passed from the front end to the back end
   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   digit;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/postfix_digit_evaluator.sv
// Top level of the postfix digit evaluator: front end, command queue,
// back end and result queue. Depends on pde_pkg and the pde_* modules.
//
//   channel   direction  handshake        payload
//   req_      in         req_push/full    pde_pkg::req_type (symbol, finish)
//   rsp_      out        rsp_pop/empty    pde_pkg::rsp_type (done_res, status, value)
//
// One item per cycle sustained while results are popped; every item yields exactly one result.
// An accepted item waits in the command queue; the stack step in the back
// end turns it into a result, written into the result queue when that
// queue has room, from where it shows on the result ports to be popped.
// Reset clears both queues and the stack count; the stack memory keeps
// its contents and needs no clearing. req_full rises when the two-entry
// command queue fills, which happens only while results are not popped.
`default_nettype none

module postfix_digit_evaluator #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire pde_pkg::req_type req_data,
   output logic                  req_full,
   input  wire logic             rsp_pop,
   output logic                  rsp_empty,
   output pde_pkg::rsp_type      rsp_data
);

   localparam int CMD_W = $bits(pde_pkg::cmd_type);
   localparam int RSP_W = $bits(pde_pkg::rsp_type);

   pde_pkg::cmd_type front_cmd, queued_cmd;
   pde_pkg::rsp_type back_rsp;
   logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic             rsp_push, rsp_full;
   logic [CMD_W-1:0] queued_bits;
   logic [RSP_W-1:0] rsp_bits;

   pde_front u_front (
      .req_data (req_data),
      .req_push (req_push),
      .req_full (req_full),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (front_cmd)
   );

   pde_fifo #(.WIDTH(CMD_W)) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (queued_bits)
   );

   assign queued_cmd = pde_pkg::cmd_type'(queued_bits);

   pde_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (queued_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (back_rsp)
   );

   pde_fifo #(.WIDTH(RSP_W)) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_bits)
   );

   assign rsp_data = pde_pkg::rsp_type'(rsp_bits);

endmodule

`default_nettype wire

### rtl/pde_fifo.sv
// Two-entry queue of flat words, used between the front and back ends
// and on the result side. Depends on nothing else.
`default_nettype none

module pde_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rd_data
);

   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

### rtl/pde_front.sv
// Front end: takes input items and classifies each character.
// Depends on pde_pkg.
`default_nettype none

module pde_front (
   input  wire pde_pkg::req_type req_data,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic             cmd_full,
   output logic                  cmd_push,
   output pde_pkg::cmd_type      cmd_data
);

   logic [7:0] offset;

   assign req_full = cmd_full;
   assign cmd_push = req_push;
   assign offset   = req_data.symbol - pde_pkg::CHAR_ZERO;

   always_comb begin
      cmd_data.digit = offset[3:0];
      if (req_data.finish) begin
         cmd_data.kind = pde_pkg::CMD_FINISH;
      end else if (req_data.symbol >= pde_pkg::CHAR_ZERO &&
                   req_data.symbol <= pde_pkg::CHAR_NINE) begin
         cmd_data.kind = pde_pkg::CMD_DIGIT;
      end else begin
         unique case (req_data.symbol)
            pde_pkg::CHAR_PLUS:  cmd_data.kind = pde_pkg::CMD_ADD;
            pde_pkg::CHAR_MINUS: cmd_data.kind = pde_pkg::CMD_SUB;
            pde_pkg::CHAR_STAR:  cmd_data.kind = pde_pkg::CMD_MUL;
            default:             cmd_data.kind = pde_pkg::CMD_BAD;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/pde_back.sv
// Back end: operand stack with top, second and third entries in registers
// and deeper entries in a memory; one classified item per cycle while a
// command is queued and the result queue has room. Depends on pde_pkg.
`default_nettype none

module pde_back #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_empty,
   input  wire pde_pkg::cmd_type cmd_data,
   output logic                  cmd_pop,
   input  wire logic             rsp_full,
   output logic                  rsp_push,
   output pde_pkg::rsp_type      rsp_data
);

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [7:0]    mem [STACK_DEPTH];
   logic [DW-1:0] depth_ff, depth_in;
   logic          seen_ff, seen_in;
   pde_pkg::status_type err_ff, err_in;
   logic [7:0]    tos_ff, tos_in;
   logic [7:0]    nos_ff, nos_in;
   logic [7:0]    third_ff;
   logic          fire, do_push, do_pop;
   logic [DW-1:0] wr_idx, rd_idx;
   logic [15:0]   product;
   logic [7:0]    alu;

   assign fire    = !cmd_empty && !rsp_full;
   assign cmd_pop = fire;
   assign rsp_push = fire;
   assign wr_idx  = depth_ff - DW'(3);
   assign rd_idx  = depth_ff - DW'(4);
   assign product = {8'd0, nos_ff} * {8'd0, tos_ff};

   always_comb begin
      case (cmd_data.kind)
         pde_pkg::CMD_ADD: alu = nos_ff + tos_ff;
         pde_pkg::CMD_SUB: alu = nos_ff - tos_ff;
         default:          alu = product[7:0];
      endcase
   end

   always_comb begin
      depth_in = depth_ff;
      seen_in  = seen_ff;
      err_in   = err_ff;
      tos_in   = tos_ff;
      nos_in   = nos_ff;
      do_push  = 1'b0;
      do_pop   = 1'b0;
      rsp_data.done_res = 1'b0;
      rsp_data.status   = err_ff;
      rsp_data.value    = '0;
      if (fire) begin
         if (cmd_data.kind == pde_pkg::CMD_FINISH) begin
            rsp_data.done_res = 1'b1;
            if (err_ff != pde_pkg::STATUS_OK) begin
               rsp_data.status = err_ff;
            end else if (depth_ff != DW'(1)) begin
               rsp_data.status = pde_pkg::STATUS_BAD_DEPTH;
            end else begin
               rsp_data.status = pde_pkg::STATUS_OK;
               rsp_data.value  = $signed(tos_ff);
            end
            depth_in = '0;
            seen_in  = 1'b0;
            err_in   = pde_pkg::STATUS_OK;
         end else begin
            if (err_ff == pde_pkg::STATUS_OK) begin
               unique case (cmd_data.kind) inside
                  pde_pkg::CMD_DIGIT: begin
                     if (depth_ff == DW'(STACK_DEPTH)) begin
                        err_in = pde_pkg::STATUS_OVERFLOW;
                     end else begin
                        do_push  = 1'b1;
                        tos_in   = {4'd0, cmd_data.digit};
                        nos_in   = tos_ff;
                        depth_in = depth_ff + DW'(1);
                        seen_in  = 1'b1;
                     end
                  end
                  pde_pkg::CMD_ADD, pde_pkg::CMD_SUB,
                  pde_pkg::CMD_MUL, pde_pkg::CMD_BAD: begin
                     if (!seen_ff) begin
                        err_in = pde_pkg::STATUS_OP_FIRST;
                     end else if (depth_ff < DW'(2)) begin
                        err_in = pde_pkg::STATUS_FEW;
                     end else if (cmd_data.kind == pde_pkg::CMD_BAD) begin
                        err_in = pde_pkg::STATUS_BAD_SYM;
                     end else begin
                        do_pop   = 1'b1;
                        tos_in   = alu;
                        nos_in   = third_ff;
                        depth_in = depth_ff - DW'(1);
                     end
                  end
                  default: ;
               endcase
            end
            rsp_data.status = err_in;
            rsp_data.value  = (depth_in != '0) ? $signed(tos_in) : 8'sd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         seen_ff  <= 1'b0;
         err_ff   <= pde_pkg::STATUS_OK;
      end else begin
         depth_ff <= depth_in;
         seen_ff  <= seen_in;
         err_ff   <= err_in;
      end
   end

   // Third entry: take the old second on a push, refill from memory on a pop
   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      nos_ff <= nos_in;
      if (do_push) begin
         third_ff <= nos_ff;
         if (depth_ff >= DW'(3)) begin
            mem[wr_idx[AW-1:0]] <= third_ff;
         end
      end else if (do_pop) begin
         third_ff <= mem[rd_idx[AW-1:0]];
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_empty_before_digit: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> depth_ff == '0)
      else $error("entries stacked before any digit");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      fire && cmd_data.kind == pde_pkg::CMD_FINISH
      |=> depth_ff == '0 && !seen_ff && err_ff == pde_pkg::STATUS_OK)
      else $error("finish did not clear state");

   a_error_freezes: assert property (@(posedge clock) disable iff (reset)
      fire && err_ff != pde_pkg::STATUS_OK && cmd_data.kind != pde_pkg::CMD_FINISH
      |=> depth_ff == $past(depth_ff) && err_ff == $past(err_ff))
      else $error("latched error let the stack change");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for postfix_digit_evaluator: directed rows, then random expressions,
// all results checked field by field against the typed rows' expected values, else an in-bench stack evaluator.
// Depends on rtl/pde_pkg.sv and rtl/postfix_digit_evaluator.sv.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_N     = 16;
   localparam int ITEM_TARGET = 1650;
   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      pde_pkg::req_type item;
      int               count;
      bit               typed;
      pde_pkg::rsp_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   pde_pkg::req_type req_data = '0;
   logic             req_full;
   logic             rsp_pop = 1'b0;
   logic             rsp_empty;
   pde_pkg::rsp_type rsp_data;

   // evaluator state
   logic [7:0]          stk [STACK_N];
   int                  depth = 0;
   bit                  seen = 1'b0;
   pde_pkg::status_type err = pde_pkg::STATUS_OK;

   pde_pkg::rsp_type results_due [$];
   stim_row_type     script [$];

   int idle_pct = 8;
   int mismatches = 0;
   int n_items = 0;
   int n_results = 0;
   int n_expr = 0;
   int n_ok = 0;
   int n_overflow = 0;
   int max_depth = 0;
   int quiet_cycles = 0;

   postfix_digit_evaluator #(.STACK_DEPTH(STACK_N)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic pde_pkg::req_type mkreq(input logic [7:0] sym, input logic fin);
      pde_pkg::req_type r;
      r.symbol = sym;
      r.finish = fin;
      return r;
   endfunction

   function automatic pde_pkg::rsp_type mk(input logic done, input pde_pkg::status_type st,
                                           input logic signed [7:0] v);
      pde_pkg::rsp_type r;
      r.done_res = done;
      r.status   = st;
      r.value    = v;
      return r;
   endfunction

   function automatic void add_row(input pde_pkg::req_type it, input int count,
                                   input bit typed, input pde_pkg::rsp_type want);
      stim_row_type row;
      row.item  = it;
      row.count = count;
      row.typed = typed;
      row.want  = want;
      script.push_back(row);
   endfunction

   // Advance the stack evaluator by one item and return its result
   function automatic pde_pkg::rsp_type eval_item(input pde_pkg::req_type it);
      pde_pkg::rsp_type r;
      logic [7:0]       s, a, b, q;
      r = '0;
      if (it.finish) begin
         r.done_res = 1'b1;
         r.status   = err;
         if (err == pde_pkg::STATUS_OK) begin
            if (depth != 1) r.status = pde_pkg::STATUS_BAD_DEPTH;
            else r.value = stk[0];
         end
         n_expr++;
         if (r.status == pde_pkg::STATUS_OK) n_ok++;
         if (r.status == pde_pkg::STATUS_OVERFLOW) n_overflow++;
         depth = 0;
         seen  = 1'b0;
         err   = pde_pkg::STATUS_OK;
         return r;
      end
      s = it.symbol;
      if (err != pde_pkg::STATUS_OK) begin
         // latched error: hold everything
      end else if (s >= pde_pkg::CHAR_ZERO && s <= pde_pkg::CHAR_NINE) begin
         if (depth >= STACK_N) begin
            err = pde_pkg::STATUS_OVERFLOW;
         end else begin
            stk[depth] = s - pde_pkg::CHAR_ZERO;
            depth++;
            seen = 1'b1;
         end
      end else if (!seen) begin
         err = pde_pkg::STATUS_OP_FIRST;
      end else if (depth < 2) begin
         err = pde_pkg::STATUS_FEW;
      end else if (s == pde_pkg::CHAR_PLUS || s == pde_pkg::CHAR_MINUS ||
                   s == pde_pkg::CHAR_STAR) begin
         b = stk[depth - 1];
         a = stk[depth - 2];
         if (s == pde_pkg::CHAR_PLUS) q = a + b;
         else if (s == pde_pkg::CHAR_MINUS) q = a - b;
         else q = a * b;
         depth--;
         stk[depth - 1] = q;
      end else begin
         err = pde_pkg::STATUS_BAD_SYM;
      end
      if (depth > max_depth) max_depth = depth;
      r.status = err;
      r.value  = (depth > 0) ? stk[depth - 1] : 8'h00;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on result %0d: %s got %0d, expected %0d", n_results, what, got, want);
      mismatches++;
   endtask

   // Offer one item, with random idle cycles ahead of it, and log its result once taken
   task automatic send_item(input pde_pkg::req_type it, input bit typed = 1'b0,
                            input pde_pkg::rsp_type want = '0);
      pde_pkg::rsp_type r;
      bit               took;
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do begin
         @(negedge clock);
         took = !req_full;
         @(posedge clock);
      end while (!took);
      r = eval_item(it);
      results_due.push_back(typed ? want : r);
      n_items++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_digit();
      return pde_pkg::CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_op();
      case ($urandom_range(2))
         0: return pde_pkg::CHAR_PLUS;
         1: return pde_pkg::CHAR_MINUS;
         default: return pde_pkg::CHAR_STAR;
      endcase
   endfunction

   // One expression plus its finish item: mostly well formed, the rest noise
   task automatic run_expression();
      int         pick, d, nd, maxd, r;
      bit         deep;
      logic [7:0] c;
      pick = $urandom_range(99);
      d    = 0;
      if (pick < 75) begin
         deep = ($urandom_range(9) == 0);
         nd   = deep ? STACK_N : $urandom_range(1, 7);
         maxd = deep ? STACK_N : $urandom_range(2, 5);
         while (nd > 0 || d > 1) begin
            if (nd > 0 && (d < 2 || (d < maxd && (deep || $urandom_range(1) == 0)))) begin
               send_item(mkreq(rand_digit(), 1'b0));
               nd--;
               d++;
            end else begin
               send_item(mkreq(rand_op(), 1'b0));
               d--;
            end
         end
      end else begin
         if (pick >= 95) begin
            // push past the top of the stack
            repeat ($urandom_range(STACK_N + 1, STACK_N + 3))
               send_item(mkreq(rand_digit(), 1'b0));
         end
         repeat ($urandom_range(0, 10)) begin
            r = $urandom_range(9);
            if (r < 4) c = rand_digit();
            else if (r < 7) c = rand_op();
            else c = 8'($urandom_range(255));
            send_item(mkreq(c, 1'b0));
         end
      end
      send_item(mkreq(8'($urandom_range(255)), 1'b1));
   endtask

   // result side: random pops, check at the falling edge ahead of the accepting edge
   initial begin
      pde_pkg::rsp_type want;
      forever begin
         @(negedge clock);
         if (rsp_pop && !rsp_empty) begin
            n_results++;
            if (results_due.size() == 0) begin
               $display("unexpected result %0d with nothing outstanding", n_results);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               if (rsp_data.done_res !== want.done_res)
                  report_mismatch("done_res", rsp_data.done_res, want.done_res);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.value !== want.value)
                  report_mismatch("value", $signed(rsp_data.value), $signed(want.value));
            end
         end
         @(posedge clock);
         rsp_pop <= !reset && ($urandom_range(99) >= idle_pct);
      end
   end

   // watchdog: count cycles with no item moving on either side
   always @(negedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, results_due.size());
         $display("[postfix_digit_evaluator] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit paused;
      paused = 1'b0;
      for (int i = 0; i < STACK_N; i++) stk[i] = 8'h00;

      add_row(mkreq(8'h00, 1'b1), 1, 1'b1,
              mk(1'b1, pde_pkg::STATUS_BAD_DEPTH, 8'sd0));
      add_row(mkreq(pde_pkg::CHAR_STAR, 1'b0), 1, 1'b1,
              mk(1'b0, pde_pkg::STATUS_OP_FIRST, 8'sd0));
      add_row(mkreq(pde_pkg::CHAR_NINE, 1'b0), 1, 1'b1,
              mk(1'b0, pde_pkg::STATUS_OP_FIRST, 8'sd0));
      add_row(mkreq(8'hFF, 1'b1), 1, 1'b1,
              mk(1'b1, pde_pkg::STATUS_OP_FIRST, 8'sd0));
      add_row(mkreq(pde_pkg::CHAR_NINE, 1'b0), 1, 1'b1,
              mk(1'b0, pde_pkg::STATUS_OK, 8'sd9));
      // a non-operator with one entry stacked still reads as too few operands
      add_row(mkreq(8'h00, 1'b0), 1, 1'b1,
              mk(1'b0, pde_pkg::STATUS_FEW, 8'sd9));
      add_row(mkreq(pde_pkg::CHAR_ZERO, 1'b1), 1, 1'b1,
              mk(1'b1, pde_pkg::STATUS_FEW, 8'sd0));
      // (9+9)*9-9 wraps negative, then fill the stack and overflow it
      add_row(mkreq(pde_pkg::CHAR_NINE, 1'b0), 2, 1'b0, '0);
      add_row(mkreq(pde_pkg::CHAR_PLUS, 1'b0), 1, 1'b0, '0);
      add_row(mkreq(pde_pkg::CHAR_NINE, 1'b0), 1, 1'b0, '0);
      add_row(mkreq(pde_pkg::CHAR_STAR, 1'b0), 1, 1'b0, '0);
      add_row(mkreq(pde_pkg::CHAR_NINE, 1'b0), 1, 1'b0, '0);
      add_row(mkreq(pde_pkg::CHAR_MINUS, 1'b0), 1, 1'b0, '0);
      add_row(mkreq(pde_pkg::CHAR_NINE, 1'b0), STACK_N - 1, 1'b0, '0);
      add_row(mkreq(pde_pkg::CHAR_ZERO, 1'b0), 1, 1'b1,
              mk(1'b0, pde_pkg::STATUS_OVERFLOW, 8'sd9));
      add_row(mkreq(pde_pkg::CHAR_NINE, 1'b1), 1, 1'b1,
              mk(1'b1, pde_pkg::STATUS_OVERFLOW, 8'sd0));
      // bad symbol with two operands, then a later operator is dropped
      add_row(mkreq(pde_pkg::CHAR_ZERO + 8'd2, 1'b0), 1, 1'b0, '0);
      add_row(mkreq(pde_pkg::CHAR_ZERO + 8'd7, 1'b0), 1, 1'b0, '0);
      add_row(mkreq(8'hFF, 1'b0), 1, 1'b1,
              mk(1'b0, pde_pkg::STATUS_BAD_SYM, 8'sd7));
      add_row(mkreq(pde_pkg::CHAR_STAR, 1'b0), 1, 1'b1,
              mk(1'b0, pde_pkg::STATUS_BAD_SYM, 8'sd7));
      add_row(mkreq(8'h00, 1'b1), 1, 1'b1,
              mk(1'b1, pde_pkg::STATUS_BAD_SYM, 8'sd0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         repeat (script[i].count) send_item(script[i].item, script[i].typed, script[i].want);
      drain_results();

      while (n_items < ITEM_TARGET) begin
         idle_pct = (n_items >= 600 && n_items < 900) ? 0 : 8;
         if (!paused && n_items >= 1100) begin
            drain_results();
            paused = 1'b1;
         end
         run_expression();
      end
      req_push <= 1'b0;

      while (results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d items in %0d expressions (%0d ok, %0d overflowed), %0d results checked",
               n_items, n_expr, n_ok, n_overflow, n_results);
      $display("deepest stack reached: %0d of %0d entries", max_depth, STACK_N);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("[postfix_digit_evaluator] OK");
      end else begin
         $display("[postfix_digit_evaluator] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
